FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL files, included by psm_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on each rising edge, skipped while reset is high
`define ASSERT_SYNC(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on each rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_SYNC(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/psm_pkg.sv
package psm_pkg;

   // Pilot state codes
   typedef logic [1:0] pilot_type;
   localparam pilot_type PILOT_A       = 2'd0;
   localparam pilot_type PILOT_B       = 2'd1;
   localparam pilot_type PILOT_C       = 2'd2;
   localparam pilot_type PILOT_UNKNOWN = 2'd3;

   // Field widths
   localparam int unsigned ADC_W    = 10;
   localparam int unsigned BUZ_W    = 16;
   localparam int unsigned LED_W    = 24;
   localparam int unsigned CSR_A_W  = 3;
   localparam int unsigned CSR_D_W  = 24;
   localparam int unsigned REQ_D_W  = 16;
   localparam int unsigned RSP_D_W  = 8;

   // Register indexes
   typedef logic [CSR_A_W-1:0] csr_addr_type;
   localparam csr_addr_type CSR_STATE_A_MIN    = 3'd0;
   localparam csr_addr_type CSR_STATE_B_MIN    = 3'd1;
   localparam csr_addr_type CSR_STATE_B_MAX    = 3'd2;
   localparam csr_addr_type CSR_STATE_C_MIN    = 3'd3;
   localparam csr_addr_type CSR_STATE_C_MAX    = 3'd4;
   localparam csr_addr_type CSR_BUZZER_MS      = 3'd5;
   localparam csr_addr_type CSR_LED_TIMEOUT_MS = 3'd6;

   // Register reset values
   localparam logic [ADC_W-1:0] RST_STATE_A_MIN    = 10'd972;
   localparam logic [ADC_W-1:0] RST_STATE_B_MIN    = 10'd717;
   localparam logic [ADC_W-1:0] RST_STATE_B_MAX    = 10'd818;
   localparam logic [ADC_W-1:0] RST_STATE_C_MIN    = 10'd461;
   localparam logic [ADC_W-1:0] RST_STATE_C_MAX    = 10'd562;
   localparam logic [BUZ_W-1:0] RST_BUZZER_MS      = 16'd500;
   localparam logic [LED_W-1:0] RST_LED_TIMEOUT_MS = 24'd10000;

   typedef struct packed {
      logic [ADC_W-1:0] state_a_min;
      logic [ADC_W-1:0] state_b_min;
      logic [ADC_W-1:0] state_b_max;
      logic [ADC_W-1:0] state_c_min;
      logic [ADC_W-1:0] state_c_max;
      logic [BUZ_W-1:0] buzzer_ms;
      logic [LED_W-1:0] led_timeout_ms;
   } cfg_type;

   // One result, packed in port order from the lowest bit up
   typedef struct packed {
      logic      leds_on;
      logic      buzzer_on;
      logic      state_changed;
      pilot_type pilot_state;
   } result_type;

endpackage

FILE: rtl/psm_csr.sv
module psm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  psm_pkg::csr_addr_type         csr_addr,
   input  logic [psm_pkg::CSR_D_W-1:0]   csr_wdata,
   output psm_pkg::cfg_type              cfg
);
   import psm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode a register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_STATE_A_MIN:    cfg_in.state_a_min    = csr_wdata[ADC_W-1:0];
            CSR_STATE_B_MIN:    cfg_in.state_b_min    = csr_wdata[ADC_W-1:0];
            CSR_STATE_B_MAX:    cfg_in.state_b_max    = csr_wdata[ADC_W-1:0];
            CSR_STATE_C_MIN:    cfg_in.state_c_min    = csr_wdata[ADC_W-1:0];
            CSR_STATE_C_MAX:    cfg_in.state_c_max    = csr_wdata[ADC_W-1:0];
            CSR_BUZZER_MS:      cfg_in.buzzer_ms      = csr_wdata[BUZ_W-1:0];
            CSR_LED_TIMEOUT_MS: cfg_in.led_timeout_ms = csr_wdata[LED_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.state_a_min    <= RST_STATE_A_MIN;
         cfg_ff.state_b_min    <= RST_STATE_B_MIN;
         cfg_ff.state_b_max    <= RST_STATE_B_MAX;
         cfg_ff.state_c_min    <= RST_STATE_C_MIN;
         cfg_ff.state_c_max    <= RST_STATE_C_MAX;
         cfg_ff.buzzer_ms      <= RST_BUZZER_MS;
         cfg_ff.led_timeout_ms <= RST_LED_TIMEOUT_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/psm_classify.sv
module psm_classify (
   input  psm_pkg::cfg_type              cfg,
   input  logic [psm_pkg::ADC_W-1:0]     adc_sample,
   output psm_pkg::pilot_type            sample_class
);
   import psm_pkg::*;

   logic in_a;
   logic in_b;
   logic in_c;

   // Window compares; an empty window never matches
   assign in_a = adc_sample >= cfg.state_a_min;
   assign in_b = (adc_sample >= cfg.state_b_min) && (adc_sample <= cfg.state_b_max);
   assign in_c = (adc_sample >= cfg.state_c_min) && (adc_sample <= cfg.state_c_max);

   // First match wins, in order A, B, C
   always_comb begin
      if (in_a) begin
         sample_class = PILOT_A;
      end else if (in_b) begin
         sample_class = PILOT_B;
      end else if (in_c) begin
         sample_class = PILOT_C;
      end else begin
         sample_class = PILOT_UNKNOWN;
      end
   end

endmodule

FILE: rtl/psm_core.sv
`include "assert_macros.svh"

module psm_core (
   input  logic                 clock,
   input  logic                 reset,
   input  psm_pkg::cfg_type     cfg,
   input  logic                 step,
   input  psm_pkg::pilot_type   sample_class,
   input  logic                 power_fail,
   output psm_pkg::result_type  result
);
   import psm_pkg::*;

   pilot_type         kept_state_ff, kept_state_in;
   logic              buzzer_on_ff, buzzer_on_in;
   logic              leds_on_ff, leds_on_in;
   logic [BUZ_W-1:0]  buz_elapsed_ff, buz_elapsed_in;
   logic [LED_W-1:0]  led_elapsed_ff, led_elapsed_in;

   logic [BUZ_W-1:0]  buz_tick;
   logic [LED_W-1:0]  led_tick;
   logic              buz_keep;
   logic              led_keep;
   logic              changed;

   // Advance both timers, saturating at all ones
   assign buz_tick = (buz_elapsed_ff == '1) ? buz_elapsed_ff : buz_elapsed_ff + 1'b1;
   assign led_tick = (led_elapsed_ff == '1) ? led_elapsed_ff : led_elapsed_ff + 1'b1;

   // Drop buzzer and LEDs on timeout, LEDs also on power fail; a zero LED timeout never expires
   assign buz_keep = buzzer_on_ff && (buz_tick < cfg.buzzer_ms);
   assign led_keep = leds_on_ff && !power_fail &&
                     !((cfg.led_timeout_ms != '0) && (led_tick >= cfg.led_timeout_ms));

   // Accept a known state that differs from the kept one
   assign changed = (sample_class != PILOT_UNKNOWN) && (sample_class != kept_state_ff);

   always_comb begin
      if (changed) begin
         kept_state_in  = sample_class;
         buzzer_on_in   = 1'b1;
         leds_on_in     = 1'b1;
         buz_elapsed_in = '0;
         led_elapsed_in = '0;
      end else begin
         kept_state_in  = kept_state_ff;
         buzzer_on_in   = buz_keep;
         leds_on_in     = led_keep;
         buz_elapsed_in = buz_tick;
         led_elapsed_in = led_tick;
      end
   end

   assign result.pilot_state   = kept_state_in;
   assign result.state_changed = changed;
   assign result.buzzer_on     = buzzer_on_in;
   assign result.leds_on       = leds_on_in;

   // Update state only when a request is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         kept_state_ff  <= PILOT_UNKNOWN;
         buzzer_on_ff   <= 1'b0;
         leds_on_ff     <= 1'b0;
         buz_elapsed_ff <= '0;
         led_elapsed_ff <= '0;
      end else if (step) begin
         kept_state_ff  <= kept_state_in;
         buzzer_on_ff   <= buzzer_on_in;
         leds_on_ff     <= leds_on_in;
         buz_elapsed_ff <= buz_elapsed_in;
         led_elapsed_ff <= led_elapsed_in;
      end
   end

   `ASSERT_ALWAYS(a_reset_unknown, clock, reset |=> (kept_state_ff == PILOT_UNKNOWN), "kept state not unknown after reset")
   `ASSERT_SYNC(a_idle_holds, clock, reset, !step |=> ($stable(kept_state_ff) && $stable(buz_elapsed_ff) && $stable(led_elapsed_ff)), "state moved without a request")
   `ASSERT_SYNC(a_pfail_leds, clock, reset, (step && power_fail && !changed) |=> !leds_on_ff, "LEDs on after power fail")
   `ASSERT_SYNC(a_change_restart, clock, reset, (step && changed) |=> (buz_elapsed_ff == '0 && led_elapsed_ff == '0 && kept_state_ff != PILOT_UNKNOWN), "timers not restarted on change")

endmodule

FILE: rtl/ev_pilot_state_monitor.sv
// Channel  | Direction | Handshake              | Payload
// req      | in        | req_tvalid/req_tready  | adc_sample, power_fail
// rsp      | out       | rsp_tvalid/rsp_tready  | pilot_state, state_changed, buzzer_on, leds_on
// csr      | in        | csr_we                 | csr_addr, csr_wdata
//
// One request per cycle while the result is not stalled; a taken request passes through the
// input register, then the result register, which loads when it is free or being taken.
// Reset is synchronous and returns the state to unknown, timers to zero and registers
// to their defaults. A stalled result holds the result register; the input register
// still takes one more request behind it.
module ev_pilot_state_monitor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [psm_pkg::REQ_D_W-1:0]     req_tdata,   // [9:0] adc_sample, [10] power_fail
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [psm_pkg::RSP_D_W-1:0]     rsp_tdata,   // [1:0] pilot_state, [2] state_changed,
                                                        // [3] buzzer_on, [4] leds_on
   input  logic                            csr_we,
   input  psm_pkg::csr_addr_type           csr_addr,
   input  logic [psm_pkg::CSR_D_W-1:0]     csr_wdata
);
   import psm_pkg::*;

   cfg_type           cfg;
   pilot_type         sample_class;
   result_type        result;

   logic              in_valid_ff, in_valid_in;
   logic [ADC_W-1:0]  in_sample_ff;
   logic              in_pfail_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_data_ff;

   logic              advance;
   logic              step;

   // Move the pipeline when the result register is free or being taken
   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture a request
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_sample_ff <= req_tdata[ADC_W-1:0];
         in_pfail_ff  <= req_tdata[ADC_W];
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= result;
      end
   end

   psm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   psm_classify u_classify (
      .cfg          (cfg),
      .adc_sample   (in_sample_ff),
      .sample_class (sample_class)
   );

   psm_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .step         (step),
      .sample_class (sample_class),
      .power_fail   (in_pfail_ff),
      .result       (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_D_W - $bits(result_type)){1'b0}}, out_data_ff};

endmodule

FILE: tb/tb.sv
module tb;
   import psm_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam csr_addr_type CSR_UNMAPPED = 3'd7;

   // One request: [9:0] adc_sample, [10] power_fail
   typedef struct packed {
      logic             power_fail;
      logic [ADC_W-1:0] adc_sample;
   } tick_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_D_W-1:0] req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_D_W-1:0] rsp_tdata;
   logic               csr_we = 1'b0;
   csr_addr_type       csr_addr = CSR_STATE_A_MIN;
   logic [CSR_D_W-1:0] csr_wdata = '0;

   // Shadow registers and pilot tracking state
   cfg_type          pilot_cfg;
   pilot_type        kept_pilot;
   logic             buzzer_level;
   logic             leds_level;
   logic [BUZ_W-1:0] buzzer_ticks;
   logic [LED_W-1:0] led_ticks;

   tick_type    pending_ticks[$];
   result_type  pilot_expected[$];
   result_type  seen_result;
   result_type  wanted_result;
   tick_type    next_tick;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned idle_cycles = 0;
   int unsigned mismatches = 0;
   logic        quiet = 1'b0;

   ev_pilot_state_monitor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Advance the pilot state by one millisecond tick and return the result
   function automatic result_type pilot_tick(input tick_type t);
      pilot_type  seen_state;
      result_type r;
      if (buzzer_ticks != '1) buzzer_ticks++;
      if (led_ticks != '1) led_ticks++;
      if (buzzer_level && buzzer_ticks >= pilot_cfg.buzzer_ms) buzzer_level = 1'b0;
      if (leds_level && pilot_cfg.led_timeout_ms != '0 &&
          led_ticks >= pilot_cfg.led_timeout_ms) leds_level = 1'b0;
      if (t.power_fail) leds_level = 1'b0;
      // windows are tried A, B, C; the first hit wins
      if (t.adc_sample >= pilot_cfg.state_a_min) begin
         seen_state = PILOT_A;
      end else if (t.adc_sample >= pilot_cfg.state_b_min &&
                   t.adc_sample <= pilot_cfg.state_b_max) begin
         seen_state = PILOT_B;
      end else if (t.adc_sample >= pilot_cfg.state_c_min &&
                   t.adc_sample <= pilot_cfg.state_c_max) begin
         seen_state = PILOT_C;
      end else begin
         seen_state = PILOT_UNKNOWN;
      end
      r.state_changed = (seen_state != PILOT_UNKNOWN) && (seen_state != kept_pilot);
      if (r.state_changed) begin
         kept_pilot   = seen_state;
         buzzer_level = 1'b1;
         leds_level   = 1'b1;
         buzzer_ticks = '0;
         led_ticks    = '0;
      end
      r.pilot_state = kept_pilot;
      r.buzzer_on   = buzzer_level;
      r.leds_on     = leds_level;
      return r;
   endfunction

   // Reset the shadow state, then predict each accepted request
   always @(posedge clock) begin
      if (reset) begin
         pilot_cfg.state_a_min    = RST_STATE_A_MIN;
         pilot_cfg.state_b_min    = RST_STATE_B_MIN;
         pilot_cfg.state_b_max    = RST_STATE_B_MAX;
         pilot_cfg.state_c_min    = RST_STATE_C_MIN;
         pilot_cfg.state_c_max    = RST_STATE_C_MAX;
         pilot_cfg.buzzer_ms      = RST_BUZZER_MS;
         pilot_cfg.led_timeout_ms = RST_LED_TIMEOUT_MS;
         kept_pilot   = PILOT_UNKNOWN;
         buzzer_level = 1'b0;
         leds_level   = 1'b0;
         buzzer_ticks = '0;
         led_ticks    = '0;
      end else if (req_tvalid && req_tready) begin
         pilot_expected.push_back(pilot_tick(tick_type'(req_tdata[10:0])));
      end
   end

   // Drive requests from the pending queue, with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap != 0) begin
            req_tvalid <= 1'b0;
            send_gap   <= send_gap - 1;
         end else if (pending_ticks.size() != 0) begin
            next_tick = pending_ticks.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {{(REQ_D_W-11){1'b0}}, next_tick};
            if (!quiet && $urandom_range(0, 11) == 0) send_gap <= $urandom_range(1, 17);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Compare each accepted result with the oldest prediction; stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_result = result_type'(rsp_tdata[4:0]);
         if (pilot_expected.size() == 0) begin
            $error("unexpected result: tdata %0h", rsp_tdata);
            mismatches++;
         end else begin
            wanted_result = pilot_expected.pop_front();
            check_field("pilot_state", wanted_result.pilot_state, seen_result.pilot_state);
            check_field("state_changed", wanted_result.state_changed,
                        seen_result.state_changed);
            check_field("buzzer_on", wanted_result.buzzer_on, seen_result.buzzer_on);
            check_field("leds_on", wanted_result.leds_on, seen_result.leds_on);
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0 && !quiet) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 13) == 0) stall_left <= $urandom_range(1, 17);
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("ev_pilot_state_monitor: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Hold until every request is out and every result is back, then let the pipe settle
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_tvalid || pilot_expected.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_addr_type idx, input logic [CSR_D_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_STATE_A_MIN:    pilot_cfg.state_a_min    = data[ADC_W-1:0];
         CSR_STATE_B_MIN:    pilot_cfg.state_b_min    = data[ADC_W-1:0];
         CSR_STATE_B_MAX:    pilot_cfg.state_b_max    = data[ADC_W-1:0];
         CSR_STATE_C_MIN:    pilot_cfg.state_c_min    = data[ADC_W-1:0];
         CSR_STATE_C_MAX:    pilot_cfg.state_c_max    = data[ADC_W-1:0];
         CSR_BUZZER_MS:      pilot_cfg.buzzer_ms      = data[BUZ_W-1:0];
         CSR_LED_TIMEOUT_MS: pilot_cfg.led_timeout_ms = data[LED_W-1:0];
         default: ;
      endcase
   endtask

   // Write all registers once the block is idle; unused upper data bits carry junk
   task automatic program_regs(input logic [ADC_W-1:0] a_min, b_min, b_max, c_min, c_max,
                               input logic [BUZ_W-1:0] buz, input logic [LED_W-1:0] led,
                               input bit poke_unmapped);
      logic [CSR_D_W-1:0] junk;
      wait_drained();
      junk = CSR_D_W'($urandom);
      write_reg(CSR_STATE_A_MIN, {junk[23:10], a_min});
      write_reg(CSR_STATE_B_MIN, {junk[13:0], b_min});
      write_reg(CSR_STATE_B_MAX, {junk[20:7], b_max});
      write_reg(CSR_STATE_C_MIN, {junk[16:3], c_min});
      write_reg(CSR_STATE_C_MAX, {~junk[13:0], c_max});
      write_reg(CSR_BUZZER_MS, {junk[7:0], buz});
      write_reg(CSR_LED_TIMEOUT_MS, led);
      if (poke_unmapped) write_reg(CSR_UNMAPPED, CSR_D_W'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_random(input bit ordered);
      int unsigned th[$];
      int unsigned led;
      repeat (5) th.push_back($urandom_range(0, 1023));
      if (ordered) th.sort();
      led = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 50);
      program_regs(ADC_W'(th[4]), ADC_W'(th[2]), ADC_W'(th[3]), ADC_W'(th[0]),
                   ADC_W'(th[1]), BUZ_W'($urandom_range(0, 25)), LED_W'(led), 1'b0);
   endtask

   // Pick a sample inside a state window, near a threshold, or anywhere
   function automatic logic [ADC_W-1:0] sample_in(input int unsigned region);
      logic [ADC_W-1:0] lo;
      logic [ADC_W-1:0] hi;
      logic [ADC_W-1:0] mark;
      case (region)
         0: begin lo = pilot_cfg.state_a_min; hi = '1; end
         1: begin lo = pilot_cfg.state_b_min; hi = pilot_cfg.state_b_max; end
         2: begin lo = pilot_cfg.state_c_min; hi = pilot_cfg.state_c_max; end
         default: begin lo = '0; hi = '1; end
      endcase
      if (lo > hi || $urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 4))
            0: mark = pilot_cfg.state_a_min;
            1: mark = pilot_cfg.state_b_min;
            2: mark = pilot_cfg.state_b_max;
            3: mark = pilot_cfg.state_c_min;
            default: mark = pilot_cfg.state_c_max;
         endcase
         return mark + ADC_W'($urandom_range(0, 2)) - 1'b1;
      end
      return ADC_W'($urandom_range(hi, lo));
   endfunction

   // Queue runs of samples that dwell in one state, so timers get to expire
   task automatic queue_runs(input int unsigned n);
      int unsigned run_len;
      int unsigned region;
      tick_type    t;
      @(negedge clock);
      while (n != 0) begin
         region  = $urandom_range(0, 3);
         run_len = $urandom_range(1, 40);
         while (run_len != 0 && n != 0) begin
            t.adc_sample = sample_in(region);
            t.power_fail = ($urandom_range(0, 19) == 0);
            pending_ticks.push_back(t);
            run_len--;
            n--;
         end
      end
   endtask

   task automatic queue_tick(input logic pf, input logic [ADC_W-1:0] adc);
      tick_type t;
      t.power_fail = pf;
      t.adc_sample = adc;
      pending_ticks.push_back(t);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Window edges at the reset thresholds, power fail on a change and on noise
      queue_tick(1'b0, 10'd1023);
      queue_tick(1'b0, 10'd972);
      queue_tick(1'b0, 10'd971);
      queue_tick(1'b0, 10'd818);
      queue_tick(1'b0, 10'd717);
      queue_tick(1'b0, 10'd716);
      queue_tick(1'b0, 10'd819);
      queue_tick(1'b0, 10'd562);
      queue_tick(1'b0, 10'd461);
      queue_tick(1'b0, 10'd460);
      queue_tick(1'b0, 10'd563);
      queue_tick(1'b0, 10'd0);
      queue_tick(1'b1, 10'd1023);
      queue_tick(1'b1, 10'h155);
      queue_tick(1'b0, 10'h2AA);
      queue_tick(1'b0, 10'd717);
      queue_tick(1'b0, 10'd717);
      queue_tick(1'b1, 10'd717);
      queue_tick(1'b0, 10'd461);

      // Overlapping windows, zero buzzer time, LEDs that never time out
      program_regs(10'd600, 10'd500, 10'd800, 10'd450, 10'd700, 16'd0, 24'd0, 1'b1);
      @(negedge clock);
      queue_tick(1'b0, 10'd650);
      queue_tick(1'b0, 10'd550);
      queue_tick(1'b0, 10'd460);
      queue_tick(1'b0, 10'd470);
      queue_tick(1'b1, 10'd1023);
      queue_tick(1'b0, 10'd1023);
      queue_tick(1'b0, 10'd1023);
      queue_runs(200);

      // Empty B window, one-tick timers
      program_regs(10'd1000, 10'd900, 10'd100, 10'd300, 10'd400, 16'd1, 24'd1, 1'b0);
      queue_runs(200);

      // Random settings, mostly with ordered windows
      repeat (4) begin
         program_random($urandom_range(0, 3) != 0);
         queue_runs(230);
      end

      // Everything is A; longest timers
      program_regs(10'd0, 10'd0, 10'd1023, 10'd0, 10'd1023, 16'hFFFF, 24'hFFFFFF, 1'b0);
      queue_runs(60);

      // A only at full scale, B takes the rest, C never wins since B also covers zero
      program_regs(10'd1023, 10'd0, 10'd1022, 10'd0, 10'd0, 16'd2, 24'd3, 1'b0);
      queue_runs(200);

      // Run the last part without idling on either side
      program_random(1'b1);
      quiet = 1'b1;
      queue_runs(250);

      wait_drained();
      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("ev_pilot_state_monitor: match");
      end else begin
         $display("ev_pilot_state_monitor: mismatch");
      end
      $finish;
   end

endmodule
